// ===== rtl/shr_pkg.sv =====
// Shared types and constants for the sample history ring.
package shr_pkg;

  localparam int DEPTH   = 64;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CAP_W   = $clog2(DEPTH + 1);
  localparam int SP_W    = 7;
  localparam int CMP_W   = (CAP_W > SP_W) ? CAP_W : SP_W;
  localparam int TIME_W  = 32;
  localparam int TEMP_W  = 16;
  localparam int HUM_W   = 7;
  localparam int LUX_W   = 16;
  localparam int PWR_W   = 16;

  localparam logic [SP_W-1:0]  SP_RESET     = SP_W'(64);
  localparam logic [CMP_W-1:0] MIN_POINTS   = CMP_W'(10);
  localparam logic [HUM_W-1:0] MAX_HUMIDITY = HUM_W'(100);

  typedef enum logic {
    ACT_ADD   = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef struct packed {
    logic [TIME_W-1:0]        ts;
    logic signed [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]         hum;
    logic [LUX_W-1:0]         lux;
    logic [PWR_W-1:0]         pwr;
  } record_t;

  typedef struct packed {
    action_t           action;
    record_t           rec;
    logic [TIME_W-1:0] win_lo;
    logic [TIME_W-1:0] win_hi;
  } item_t;

endpackage

// ===== rtl/shr_front.sv =====
// Front end: takes commands, saturates humidity, queues them for the back end.
module shr_front
  import shr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_action,
  input  logic [TIME_W-1:0]        in_sample_time,
  input  logic signed [TEMP_W-1:0] in_temperature,
  input  logic [HUM_W-1:0]         in_humidity,
  input  logic [LUX_W-1:0]         in_illuminance,
  input  logic [PWR_W-1:0]         in_real_power,
  input  logic [TIME_W-1:0]        in_window_start,
  input  logic [TIME_W-1:0]        in_window_end,
  output logic                     q_vld,
  output item_t                    q_item,
  input  logic                     q_pop
);

  item_t       fifo_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;
  item_t       item_c;

  assign busy  = (cnt_r == 2'd2);
  assign push  = start && !busy;
  assign q_vld = (cnt_r != 2'd0);
  assign q_item = fifo_r[rd_ptr_r];

  always_comb begin
    item_c.action   = action_t'(in_action);
    item_c.rec.ts   = in_sample_time;
    item_c.rec.temp = in_temperature;
    // clamp humidity to the percent range
    item_c.rec.hum  = (in_humidity > MAX_HUMIDITY) ? MAX_HUMIDITY : in_humidity;
    item_c.rec.lux  = in_illuminance;
    item_c.rec.pwr  = in_real_power;
    item_c.win_lo   = in_window_start;
    item_c.win_hi   = in_window_end;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= item_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop && q_vld) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      unique case ({push, q_pop && q_vld})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) && !push |=> cnt_r == 2'd0) else $error("queue count rose without push");
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) && !q_pop |=> busy) else $error("queue lost an entry");

endmodule

// ===== rtl/shr_back.sv =====
// Back end: record memory, write pointer and the time-window walk.
module shr_back
  import shr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [SP_W-1:0]          store_points,
  input  logic                     q_vld,
  input  item_t                    q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  output logic                     out_match_valid,
  output logic [TIME_W-1:0]        out_found_time,
  output logic signed [TEMP_W-1:0] out_found_temperature,
  output logic [HUM_W-1:0]         out_found_humidity,
  output logic [LUX_W-1:0]         out_found_illuminance,
  output logic [PWR_W-1:0]         out_found_power,
  output logic                     out_last
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_FINISH} state_t;
  typedef enum logic {SEG_UPPER, SEG_LOWER} seg_t;

  record_t           mem [DEPTH];
  record_t           rd_data_r;
  state_t            state_r;
  seg_t              seg_r;
  logic [PTR_W-1:0]  wp_r, idx_r;
  logic              full_r;
  logic              rd_vld_r;
  logic [TIME_W-1:0] lo_r, hi_r;
  logic              pend_vld_r;
  record_t           pend_r;
  logic              out_valid_r, out_match_r, out_last_r;
  record_t           out_rec_r;

  logic [CMP_W-1:0]  sp_ext, cap, wp_ext, wp_inc, idx_inc;
  logic              mem_we, mem_re, walk_end, hit;

  always_comb begin
    sp_ext = CMP_W'(store_points);
    if (sp_ext < MIN_POINTS) begin
      cap = MIN_POINTS;
    end else if (sp_ext > CMP_W'(DEPTH)) begin
      cap = CMP_W'(DEPTH);
    end else begin
      cap = sp_ext;
    end
    wp_ext  = CMP_W'(wp_r);
    wp_inc  = wp_ext + CMP_W'(1);
    idx_inc = CMP_W'(idx_r) + CMP_W'(1);
    unique case (seg_r)
      SEG_UPPER: walk_end = (idx_inc >= cap) && (wp_r == '0);
      SEG_LOWER: walk_end = (idx_inc == wp_ext);
      default:   walk_end = 1'b1;
    endcase
  end

  assign q_pop  = (state_r == S_IDLE);
  assign mem_we = (state_r == S_IDLE) && q_vld && (q_item.action == ACT_ADD);
  assign mem_re = (state_r == S_WALK);
  assign hit    = (rd_data_r.ts >= lo_r) && (rd_data_r.ts <= hi_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= q_item.rec;
    end
    if (mem_re) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seg_r       <= SEG_LOWER;
      wp_r        <= '0;
      idx_r       <= '0;
      full_r      <= 1'b0;
      rd_vld_r    <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_match_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rd_vld_r    <= mem_re;

      // a new hit releases the one held before it, which is then not the last
      if (rd_vld_r && hit) begin
        if (pend_vld_r) begin
          out_valid_r <= 1'b1;
          out_match_r <= 1'b1;
          out_last_r  <= 1'b0;
          out_rec_r   <= pend_r;
        end
        pend_r     <= rd_data_r;
        pend_vld_r <= 1'b1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (q_vld) begin
            if (q_item.action == ACT_ADD) begin
              if (wp_inc >= cap) begin
                wp_r   <= '0;
                full_r <= 1'b1;
              end else begin
                wp_r <= PTR_W'(wp_inc);
              end
            end else begin
              lo_r       <= q_item.win_lo;
              hi_r       <= q_item.win_hi;
              pend_vld_r <= 1'b0;
              if (full_r && (wp_ext < cap)) begin
                seg_r   <= SEG_UPPER;
                idx_r   <= wp_r;
                state_r <= S_WALK;
              end else if (wp_r != '0) begin
                seg_r   <= SEG_LOWER;
                idx_r   <= '0;
                state_r <= S_WALK;
              end else begin
                state_r <= S_FINISH;
              end
            end
          end
        end
        S_WALK: begin
          if (walk_end) begin
            state_r <= S_DRAIN;
          end else if ((seg_r == SEG_UPPER) && (idx_inc >= cap)) begin
            seg_r <= SEG_LOWER;
            idx_r <= '0;
          end else begin
            idx_r <= PTR_W'(idx_inc);
          end
        end
        S_DRAIN: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          out_valid_r <= 1'b1;
          out_match_r <= pend_vld_r;
          out_last_r  <= 1'b1;
          out_rec_r   <= pend_vld_r ? pend_r : '0;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_match_valid       = out_match_r;
  assign out_last              = out_last_r;
  assign out_found_time        = out_rec_r.ts;
  assign out_found_temperature = out_rec_r.temp;
  assign out_found_humidity    = out_rec_r.hum;
  assign out_found_illuminance = out_rec_r.lux;
  assign out_found_power       = out_rec_r.pwr;

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_match_r |-> out_last_r) else $error("empty transaction not last");
  a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINISH |=> out_valid_r && out_last_r) else $error("query ended silently");
  a_read_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_WALK) || (state_r == S_DRAIN)) else $error("stray read data");
  a_drain_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN |-> $past(state_r) == S_WALK) else $error("drain without walk");

endmodule

// ===== rtl/sample_history_ring_with_time_query_unit.sv =====
// Top level of the sample history ring with time-window query.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------------------
//   input    | start in, busy out      | in_action, in_sample_time .. in_window_end
//   result   | out_valid strobe        | out_match_valid, out_found_*, out_last
//   config   | cfg_wr_en               | cfg_wr_data (store_points)
//
// An add is written from the queue head in the idle state; a query walks its ring
// entries one entry per cycle through the single read port of the record memory.
// A two-entry command queue lets new commands be taken while a query walks; busy
// rises only when that queue is full.
// Reset clears the pointer, full flag and queue; record storage is not cleared.
// Results go out one per cycle and cannot be stalled by the receiver.
module sample_history_ring_with_time_query_unit
  import shr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_action,
  input  logic [TIME_W-1:0]        in_sample_time,
  input  logic signed [TEMP_W-1:0] in_temperature,
  input  logic [HUM_W-1:0]         in_humidity,
  input  logic [LUX_W-1:0]         in_illuminance,
  input  logic [PWR_W-1:0]         in_real_power,
  input  logic [TIME_W-1:0]        in_window_start,
  input  logic [TIME_W-1:0]        in_window_end,
  output logic                     out_valid,
  output logic                     out_match_valid,
  output logic [TIME_W-1:0]        out_found_time,
  output logic signed [TEMP_W-1:0] out_found_temperature,
  output logic [HUM_W-1:0]         out_found_humidity,
  output logic [LUX_W-1:0]         out_found_illuminance,
  output logic [PWR_W-1:0]         out_found_power,
  output logic                     out_last,
  input  logic                     cfg_wr_en,
  input  logic [SP_W-1:0]          cfg_wr_data
);

  logic [SP_W-1:0] store_points_r;
  logic            q_vld, q_pop;
  item_t           q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_points_r <= SP_RESET;
    end else if (cfg_wr_en) begin
      store_points_r <= cfg_wr_data;
    end
  end

  shr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_sample_time  (in_sample_time),
    .in_temperature  (in_temperature),
    .in_humidity     (in_humidity),
    .in_illuminance  (in_illuminance),
    .in_real_power   (in_real_power),
    .in_window_start (in_window_start),
    .in_window_end   (in_window_end),
    .q_vld           (q_vld),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  shr_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .store_points          (store_points_r),
    .q_vld                 (q_vld),
    .q_item                (q_item),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_match_valid       (out_match_valid),
    .out_found_time        (out_found_time),
    .out_found_temperature (out_found_temperature),
    .out_found_humidity    (out_found_humidity),
    .out_found_illuminance (out_found_illuminance),
    .out_found_power       (out_found_power),
    .out_last              (out_last)
  );

endmodule
